/* hw/rtl/mi3_pkg.sv */
// Package for the 3x3 matrix transpose / cofactor / adjugate / inverse unit.
// Holds widths, the mode codes, the channel and queue item types and saturation.
// No dependencies.
package mi3_pkg;

  localparam int EW   = 32;            // element width
  localparam int FB   = 16;            // fraction bits
  localparam int MW   = 2 * EW + 1;    // signed 2x2 minor width
  localparam int CW   = MW - FB;       // cofactor width after the fraction shift
  localparam int DETW = EW + MW + 2;   // exact determinant width
  localparam int DQW  = DETW - 2 * FB; // determinant width after its shift
  localparam int SATW = (DQW > MW + 1) ? DQW : MW + 1;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    MODE_TRN = 2'd0,
    MODE_COF = 2'd1,
    MODE_ADJ = 2'd2,
    MODE_INV = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic signed [EW-1:0] m00;
    logic signed [EW-1:0] m01;
    logic signed [EW-1:0] m02;
    logic signed [EW-1:0] m10;
    logic signed [EW-1:0] m11;
    logic signed [EW-1:0] m12;
    logic signed [EW-1:0] m20;
    logic signed [EW-1:0] m21;
    logic signed [EW-1:0] m22;
  } in_item_t;

  typedef struct packed {
    logic signed [EW-1:0] r00;
    logic signed [EW-1:0] r01;
    logic signed [EW-1:0] r02;
    logic signed [EW-1:0] r10;
    logic signed [EW-1:0] r11;
    logic signed [EW-1:0] r12;
    logic signed [EW-1:0] r20;
    logic signed [EW-1:0] r21;
    logic signed [EW-1:0] r22;
    logic signed [EW-1:0] det_value;
    logic                 singular;
    logic                 saturated;
  } out_item_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    mode_t                  mode;
    logic [8:0][EW-1:0]     m;
    logic [8:0][CW-1:0]     cq;
    logic [DQW-1:0]         detq;
  } fe_item_t;

  // Returns {clip, value} with value clipped to the signed element range.
  function automatic logic [EW:0] sat_elem(input logic [SATW-1:0] v);
    logic [SATW-EW:0] hi;
    hi = v[SATW-1:EW-1];
    if (&hi || ~|hi) return {1'b0, v[EW-1:0]};
    else if (v[SATW-1]) return {1'b1, 1'b1, {(EW-1){1'b0}}};
    else return {1'b1, 1'b0, {(EW-1){1'b1}}};
  endfunction

endpackage

/* hw/rtl/mi3_front.sv */
// Front part: takes matrices, forms minors, cofactors and the determinant.
// Three register stages; depends on mi3_pkg.
module mi3_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mi3_pkg::in_item_t  in_data,
  output logic               push,
  output mi3_pkg::fe_item_t  push_data,
  input  logic               q_full
);
  import mi3_pkg::*;

  logic adv;
  logic a_vld_r, b_vld_r, c_vld_r;
  logic a_vld_nxt, b_vld_nxt, c_vld_nxt;

  logic signed [EW-1:0]   mv [9];
  logic signed [EW-1:0]   ma_r [9];
  logic signed [EW-1:0]   mb_r [9];
  logic signed [EW-1:0]   mc_r [9];
  logic signed [2*EW-1:0] pa_r [9][2];
  logic signed [MW-1:0]   mn_r [9];
  logic signed [MW-1:0]   mn_nxt [9];
  logic [CW-1:0]          cq_r [9];
  logic signed [2*EW:0]   plo_r [3];
  logic signed [2*EW:0]   phi_r [3];
  mode_t                  mode_a_r, mode_b_r, mode_c_r;
  logic signed [DETW-1:0] det;

  assign adv      = !c_vld_r || !q_full;
  assign in_stall = !adv;
  assign push     = c_vld_r && !q_full;

  assign mv[0] = in_data.m00;
  assign mv[1] = in_data.m01;
  assign mv[2] = in_data.m02;
  assign mv[3] = in_data.m10;
  assign mv[4] = in_data.m11;
  assign mv[5] = in_data.m12;
  assign mv[6] = in_data.m20;
  assign mv[7] = in_data.m21;
  assign mv[8] = in_data.m22;

  assign a_vld_nxt = in_valid;
  assign b_vld_nxt = a_vld_r;
  assign c_vld_nxt = b_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
      c_vld_r <= c_vld_nxt;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_el
    localparam int I  = k / 3;
    localparam int J  = k % 3;
    localparam int R0 = (I == 0) ? 1 : 0;
    localparam int R1 = (I == 2) ? 1 : 2;
    localparam int C0 = (J == 0) ? 1 : 0;
    localparam int C1 = (J == 2) ? 1 : 2;

    // Cofactor sign folded into the order of the subtraction.
    assign mn_nxt[k] = ((I + J) % 2 == 1) ?
                       MW'(pa_r[k][1]) - MW'(pa_r[k][0]) :
                       MW'(pa_r[k][0]) - MW'(pa_r[k][1]);

    always_ff @(posedge clk) begin
      if (adv) begin
        ma_r[k]    <= mv[k];
        pa_r[k][0] <= mv[R0*3+C0] * mv[R1*3+C1];
        pa_r[k][1] <= mv[R0*3+C1] * mv[R1*3+C0];
        mb_r[k]    <= ma_r[k];
        mn_r[k]    <= mn_nxt[k];
        mc_r[k]    <= mb_r[k];
        cq_r[k]    <= mn_r[k][MW-1:FB];
      end
    end
  end

  // The row-0 minors are split into a low unsigned and a high signed part so
  // each determinant product stays near 32 by 32 bits.
  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      if (adv) begin
        plo_r[j] <= mb_r[j] * $signed({1'b0, mn_r[j][EW-1:0]});
        phi_r[j] <= mb_r[j] * $signed(mn_r[j][MW-1:EW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_a_r <= in_data.mode;
      mode_b_r <= mode_a_r;
      mode_c_r <= mode_b_r;
    end
  end

  assign det = (DETW'(phi_r[0]) <<< EW) + DETW'(plo_r[0])
             + (DETW'(phi_r[1]) <<< EW) + DETW'(plo_r[1])
             + (DETW'(phi_r[2]) <<< EW) + DETW'(plo_r[2]);

  always_comb begin
    push_data.mode = mode_c_r;
    push_data.detq = det[DETW-1:2*FB];
    for (int k = 0; k < 9; k++) begin
      push_data.m[k]  = mc_r[k];
      push_data.cq[k] = cq_r[k];
    end
  end

endmodule

/* hw/rtl/mi3_queue.sv */
// Short queue between the front and back parts of the matrix unit.
// Register-based, first-word read from the head; depends on mi3_pkg.
module mi3_queue #(
  parameter int DEPTH = mi3_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  mi3_pkg::fe_item_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output mi3_pkg::fe_item_t rd_data,
  output logic              empty
);
  import mi3_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  fe_item_t       mem_r [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (rd_en) rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 1'b1;
    else if (rd_en && !wr_en) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

/* hw/rtl/mi3_back.sv */
// Back part: selects each element by mode and runs nine pipelined restoring
// dividers, one quotient bit per stage, then saturates. Depends on mi3_pkg.
module mi3_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  mi3_pkg::fe_item_t  q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mi3_pkg::out_item_t out_data
);
  import mi3_pkg::*;

  logic adv;
  logic [MW:0] vld_r;

  logic [DQW-1:0] den_r   [MW+1];
  logic [8:0]     neg_r   [MW+1];
  logic [DQW-1:0] rem_r   [MW+1][9];
  logic [MW-1:0]  nq_r    [MW+1][9];
  logic [EW-1:0]  detv_r  [MW+1];
  logic           dclip_r [MW+1];
  logic           sing_r  [MW+1];

  logic signed [DQW-1:0] detq;
  logic                  dzero, ld_sing;
  logic [DQW-1:0]        ld_den;
  logic signed [MW-1:0]  ld_v [9];
  logic [EW:0]           dsat;

  logic                  out_valid_r;
  out_item_t             out_data_r, out_data_nxt;
  logic [EW:0]           qsat [9];
  logic signed [MW:0]    sv [9];

  assign adv       = !out_valid_r || !out_stall;
  assign pop       = !q_empty && adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Load: divisions by one carry the non-inverse modes through unchanged.
  assign detq    = $signed(q_data.detq);
  assign dzero   = (q_data.detq == '0);
  assign ld_sing = (q_data.mode == MODE_INV) && dzero;
  assign ld_den  = (q_data.mode == MODE_INV && !dzero) ?
                   (detq[DQW-1] ? DQW'(-detq) : q_data.detq) : DQW'(1);
  assign dsat    = sat_elem(SATW'(detq));

  for (genvar k = 0; k < 9; k++) begin : g_ld
    localparam int I = k / 3;
    localparam int J = k % 3;
    always_comb begin
      unique case (q_data.mode)
        MODE_TRN: ld_v[k] = MW'($signed(q_data.m[J*3+I]));
        MODE_COF: ld_v[k] = MW'($signed(q_data.cq[I*3+J]));
        MODE_ADJ: ld_v[k] = MW'($signed(q_data.cq[J*3+I]));
        MODE_INV: ld_v[k] = ld_sing ? '0 : $signed({q_data.cq[J*3+I], FB'(0)});
        default:  ld_v[k] = '0;
      endcase
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[0][k] <= '0;
        nq_r[0][k]  <= ld_v[k][MW-1] ? MW'(-ld_v[k]) : ld_v[k];
        neg_r[0][k] <= ld_v[k][MW-1] ^
                       ((q_data.mode == MODE_INV) && !dzero && detq[DQW-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r[0]   <= ld_den;
      detv_r[0]  <= dsat[EW-1:0];
      dclip_r[0] <= dsat[EW];
      sing_r[0]  <= ld_sing;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[MW-1:0], pop};
  end

  for (genvar s = 0; s < MW; s++) begin : g_st
    for (genvar l = 0; l < 9; l++) begin : g_ln
      logic [DQW:0] remx;
      logic         ge;
      assign remx = {rem_r[s][l], nq_r[s][l][MW-1]};
      assign ge   = (remx >= {1'b0, den_r[s]});
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[s+1][l] <= ge ? DQW'(remx - {1'b0, den_r[s]}) : remx[DQW-1:0];
          nq_r[s+1][l]  <= {nq_r[s][l][MW-2:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[s+1]   <= den_r[s];
        neg_r[s+1]   <= neg_r[s];
        detv_r[s+1]  <= detv_r[s];
        dclip_r[s+1] <= dclip_r[s];
        sing_r[s+1]  <= sing_r[s];
      end
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_fin
    assign sv[k]   = neg_r[MW][k] ? -$signed({1'b0, nq_r[MW][k]})
                                  : $signed({1'b0, nq_r[MW][k]});
    assign qsat[k] = sat_elem(SATW'(sv[k]));
  end

  always_comb begin
    out_data_nxt.r00       = qsat[0][EW-1:0];
    out_data_nxt.r01       = qsat[1][EW-1:0];
    out_data_nxt.r02       = qsat[2][EW-1:0];
    out_data_nxt.r10       = qsat[3][EW-1:0];
    out_data_nxt.r11       = qsat[4][EW-1:0];
    out_data_nxt.r12       = qsat[5][EW-1:0];
    out_data_nxt.r20       = qsat[6][EW-1:0];
    out_data_nxt.r21       = qsat[7][EW-1:0];
    out_data_nxt.r22       = qsat[8][EW-1:0];
    out_data_nxt.det_value = detv_r[MW];
    out_data_nxt.singular  = sing_r[MW];
    out_data_nxt.saturated = dclip_r[MW] | qsat[0][EW] | qsat[1][EW] | qsat[2][EW]
                           | qsat[3][EW] | qsat[4][EW] | qsat[5][EW]
                           | qsat[6][EW] | qsat[7][EW] | qsat[8][EW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= vld_r[MW];
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= out_data_nxt;
  end

endmodule

/* hw/rtl/matrix3x3_inverse_unit_core.sv */
// 3x3 matrix unit: transpose, cofactors, adjugate or inverse of a Q16.16 matrix.
// An input transfer passes through 3 front stages, the queue, a load stage,
// 65 divider stages (one quotient bit each) and the output register.
// Throughput is one matrix per cycle while no stall holds the pipeline; the divider pipeline sets the latency.
// Reset is synchronous and active low; it empties the pipeline and the queue.
module matrix3x3_inverse_unit_core #(
  parameter int QUEUE_DEPTH = mi3_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mi3_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mi3_pkg::out_item_t out_data
);
  import mi3_pkg::*;

  // The front part computes minors, cofactors and the exact determinant and
  // writes one classified item per transfer into the queue.
  logic     push, q_full, q_empty, pop;
  fe_item_t push_data, q_data;

  mi3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // The queue lets the front keep taking transfers while the back is held
  // by a stalled output, and the other way round.
  mi3_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_data),
    .full    (q_full),
    .rd_en   (pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // The back part divides the adjugate by the determinant (or passes values
  // through a division by one), saturates and holds the result register.
  mi3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
